[hdl/ffl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ffl_pkg
// Shared widths, operation and status codes, and cell types for the
// first-fit free block table.
// ----------------------------------------------------------------------------
package ffl_pkg;

  localparam int KIND_W    = 3;
  localparam int ADDR_W    = 32;
  localparam int IDX_W     = 4;
  localparam int STATUS_W  = 2;
  localparam int DEPTH_DEF = 16;

  localparam logic [KIND_W-1:0] KIND_APPEND  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SEARCH  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RM_AT   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RM_LAST = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RD_LAST = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

  // value handed down the probe chain toward cell 0
  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  pos;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
  } probe_t;

  // per-cell controls from the sequencer
  typedef struct packed {
    logic wr;
    logic shift;
    logic clr;
    logic scan;
    logic hit_en;
    logic fit_mode;
  } cell_ctl_t;

endpackage
`default_nettype wire

[hdl/ffl_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ffl_if
// Request and result channels of the first-fit free block table.
// ----------------------------------------------------------------------------
interface ffl_req_if;
  import ffl_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ADDR_W-1:0] start_req;
  logic [ADDR_W-1:0] size;
  logic [IDX_W-1:0]  index;

  modport source (output valid, output kind, output start_req, output size,
                  output index, input ready);
  modport sink   (input valid, input kind, input start_req, input size,
                  input index, output ready);
endinterface

interface ffl_res_if;
  import ffl_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    position;
  logic [ADDR_W-1:0]   block_start;
  logic [ADDR_W-1:0]   block_size;

  modport source (output valid, output status, output position,
                  output block_start, output block_size, input ready);
  modport sink   (input valid, input status, input position,
                  input block_start, input block_size, output ready);
endinterface
`default_nettype wire

[hdl/first_fit_free_block_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_free_block_table
// Ordered table of free blocks with append, first-fit search, remove at
// position, remove last and read last, built as a row of entry cells.
// ----------------------------------------------------------------------------
// One request is handled at a time. Append, and any request answered with an
// error (empty table, bad position, unknown kind), gives its result in the
// cycle after acceptance. Search, remove at position, remove last and read
// last run the probe chain through the row of cells in state S_SCAN, as the
// matching entry moves one cell per cycle toward cell 0; the result is then
// loaded from cell 0 in state S_HOLD. A new request is taken in the cycle
// the previous result is consumed. Entries are held in DEPTH cells; positions
// reported are the low four bits of the table position.
module first_fit_free_block_table #(
  parameter int DEPTH = ffl_pkg::DEPTH_DEF
) (
  input  wire       clk,
  input  wire       rst_n,
  ffl_req_if.sink   in_ch,
  ffl_res_if.source out_ch
);
  import ffl_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       scan_cnt_r, scan_cnt_nxt;
  logic [CW-1:0]       target_r, target_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [ADDR_W-1:0]   req_r, req_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [IDX_W-1:0]    out_pos_r, out_pos_nxt;
  logic [ADDR_W-1:0]   out_start_r, out_start_nxt;
  logic [ADDR_W-1:0]   out_size_r, out_size_nxt;

  logic                in_fire, out_fire, hold_fire, slot_free;
  logic                full, empty, bad_pos, do_append;
  logic                imm_res, scan_go;
  logic [STATUS_W-1:0] imm_status;
  logic [IDX_W-1:0]    imm_pos;
  logic [ADDR_W-1:0]   imm_start, imm_size;

  logic [ADDR_W-1:0]   start_w [DEPTH+1];
  logic [ADDR_W-1:0]   size_w  [DEPTH+1];
  probe_t              probe_w [DEPTH+1];
  cell_ctl_t           ctl_w   [DEPTH];

  assign slot_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE) && slot_free;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_fire     = out_valid_r && out_ch.ready;
  assign hold_fire    = (state_r == S_HOLD) && slot_free;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign bad_pos = (CMPW'(in_ch.index) >= CMPW'(count_r));

  // requests answered at once, or handed to the probe chain
  always_comb begin
    imm_res    = 1'b0;
    scan_go    = 1'b0;
    imm_status = ST_NONE;
    imm_pos    = '0;
    imm_start  = '0;
    imm_size   = '0;
    case (in_ch.kind) inside
      KIND_APPEND: begin
        imm_res = 1'b1;
        if (full) begin
          imm_status = ST_FULL;
        end else begin
          imm_status = ST_OK;
          imm_pos    = IDX_W'(count_r);
          imm_start  = in_ch.start_req;
          imm_size   = in_ch.size;
        end
      end
      KIND_SEARCH, KIND_RM_LAST, KIND_RD_LAST: begin
        if (empty) begin
          imm_res = 1'b1;
        end else begin
          scan_go = 1'b1;
        end
      end
      KIND_RM_AT: begin
        if (empty) begin
          imm_res = 1'b1;
        end else if (bad_pos) begin
          imm_res    = 1'b1;
          imm_status = ST_BADPOS;
        end else begin
          scan_go = 1'b1;
        end
      end
      default: begin
        imm_res = 1'b1;
      end
    endcase
  end

  assign do_append = in_fire && (in_ch.kind == KIND_APPEND) && !full;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    scan_cnt_nxt = scan_cnt_r;
    target_nxt   = target_r;
    kind_nxt     = kind_r;
    req_nxt      = req_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && scan_go) begin
          state_nxt    = S_SCAN;
          scan_cnt_nxt = count_r;
          kind_nxt     = in_ch.kind;
          req_nxt      = in_ch.size;
          target_nxt   = (in_ch.kind == KIND_RM_AT) ? CW'(in_ch.index)
                                                    : count_r - CW'(1);
        end
      end
      S_SCAN: begin
        scan_cnt_nxt = scan_cnt_r - CW'(1);
        if (scan_cnt_r == CW'(1)) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (hold_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (do_append) begin
      count_nxt = count_r + CW'(1);
    end else if (hold_fire && ((kind_r == KIND_RM_AT) || (kind_r == KIND_RM_LAST))) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_fire;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_start_nxt  = out_start_r;
    out_size_nxt   = out_size_r;
    if (in_fire && imm_res) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = imm_status;
      out_pos_nxt    = imm_pos;
      out_start_nxt  = imm_start;
      out_size_nxt   = imm_size;
    end else if (hold_fire) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = probe_w[0].found ? ST_OK : ST_NONE;
      out_pos_nxt    = probe_w[0].found ? probe_w[0].pos : '0;
      out_start_nxt  = probe_w[0].found ? probe_w[0].start : '0;
      out_size_nxt   = probe_w[0].found ? probe_w[0].size : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    target_r     <= target_nxt;
    kind_r       <= kind_nxt;
    req_r        <= req_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_start_r  <= out_start_nxt;
    out_size_r   <= out_size_nxt;
  end

  assign start_w[DEPTH] = '0;
  assign size_w[DEPTH]  = '0;
  assign probe_w[DEPTH] = '0;

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    always_comb begin
      ctl_w[j].wr       = do_append && (int'(count_r) == j);
      ctl_w[j].shift    = hold_fire && (kind_r == KIND_RM_AT) &&
                          (j >= int'(target_r)) && (j + 1 < int'(count_r));
      ctl_w[j].clr      = in_fire && scan_go;
      ctl_w[j].scan     = (state_r == S_SCAN);
      ctl_w[j].fit_mode = (kind_r == KIND_SEARCH);
      ctl_w[j].hit_en   = (kind_r == KIND_SEARCH) ? (j < int'(count_r))
                                                  : (j == int'(target_r));
    end

    ffl_cell u_cell (
      .clk       (clk),
      .ctl       (ctl_w[j]),
      .cell_pos  (IDX_W'(j)),
      .wr_start  (in_ch.start_req),
      .wr_size   (in_ch.size),
      .fit_req   (req_r),
      .nxt_start (start_w[j+1]),
      .nxt_size  (size_w[j+1]),
      .probe_in  (probe_w[j+1]),
      .start_o   (start_w[j]),
      .size_o    (size_w[j]),
      .probe_o   (probe_w[j])
    );
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.position    = out_pos_r;
  assign out_ch.block_start = out_start_r;
  assign out_ch.block_size  = out_size_r;

  // entry count stays within the table
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= DEPTH)
    else $error("entry count beyond table depth");

  // an accepted transaction either answers at once or starts a scan
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (out_valid_r || (state_r == S_SCAN)))
    else $error("accepted transaction made no progress");

  // the result register is empty while a scan is in flight
  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !out_valid_r)
    else $error("result pending during scan");

  // a scan never runs with an exhausted step count
  a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (scan_cnt_r != '0))
    else $error("scan step count underflow");

endmodule
`default_nettype wire

[hdl/ffl_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ffl_cell
// One table entry plus one stage of the probe chain that carries the
// first matching entry toward cell 0.
// ----------------------------------------------------------------------------
module ffl_cell (
  input  wire                         clk,
  input  wire ffl_pkg::cell_ctl_t     ctl,
  input  wire [ffl_pkg::IDX_W-1:0]    cell_pos,
  input  wire [ffl_pkg::ADDR_W-1:0]   wr_start,
  input  wire [ffl_pkg::ADDR_W-1:0]   wr_size,
  input  wire [ffl_pkg::ADDR_W-1:0]   fit_req,
  input  wire [ffl_pkg::ADDR_W-1:0]   nxt_start,
  input  wire [ffl_pkg::ADDR_W-1:0]   nxt_size,
  input  wire ffl_pkg::probe_t        probe_in,
  output logic [ffl_pkg::ADDR_W-1:0]  start_o,
  output logic [ffl_pkg::ADDR_W-1:0]  size_o,
  output ffl_pkg::probe_t             probe_o
);
  import ffl_pkg::*;

  logic [ADDR_W-1:0] start_r, start_nxt;
  logic [ADDR_W-1:0] size_r, size_nxt;
  probe_t            probe_r, probe_nxt;
  logic              match;

  assign match = ctl.hit_en && (!ctl.fit_mode || (size_r >= fit_req));

  always_comb begin
    start_nxt = start_r;
    size_nxt  = size_r;
    if (ctl.wr) begin
      start_nxt = wr_start;
      size_nxt  = wr_size;
    end else if (ctl.shift) begin
      start_nxt = nxt_start;
      size_nxt  = nxt_size;
    end
  end

  always_comb begin
    probe_nxt = probe_r;
    if (ctl.clr) begin
      probe_nxt = '0;
    end else if (ctl.scan) begin
      if (match) begin
        probe_nxt.found = 1'b1;
        probe_nxt.pos   = cell_pos;
        probe_nxt.start = start_r;
        probe_nxt.size  = size_r;
      end else begin
        probe_nxt = probe_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    size_r  <= size_nxt;
    probe_r <= probe_nxt;
  end

  assign start_o = start_r;
  assign size_o  = size_r;
  assign probe_o = probe_r;

endmodule
`default_nettype wire
